FILE: rtl/core/qgk_pkg.sv
// Package for the quiet-gap keyed transmit controller.
// Holds the item, result, configuration and state types plus phase and notice codes.
// No dependencies.
package qgk_pkg;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ARM   = 2'd1;
    localparam logic [1:0] OP_ABORT = 2'd2;

    localparam logic [1:0] PH_IDLE      = 2'd0;
    localparam logic [1:0] PH_ARMED     = 2'd1;
    localparam logic [1:0] PH_KEYING    = 2'd2;
    localparam logic [1:0] PH_RELEASING = 2'd3;

    localparam logic [2:0] NT_NONE      = 3'd0;
    localparam logic [2:0] NT_DIGITAL   = 3'd1;
    localparam logic [2:0] NT_ARMED     = 3'd2;
    localparam logic [2:0] NT_CANCELLED = 3'd3;
    localparam logic [2:0] NT_GAVE_UP   = 3'd4;
    localparam logic [2:0] NT_SENT      = 3'd5;

    localparam logic [2:0] REG_ARM_TIMEOUT  = 3'd0;
    localparam logic [2:0] REG_GAP_GUARD    = 3'd1;
    localparam logic [2:0] REG_TX_HOLD      = 3'd2;
    localparam logic [2:0] REG_TARGET_GROUP = 3'd3;
    localparam logic [2:0] REG_CALL_FLAG    = 3'd4;

    localparam logic [31:0] ARM_TIMEOUT_RST  = 32'd30000;
    localparam logic [31:0] GAP_GUARD_RST    = 32'd300;
    localparam logic [31:0] TX_HOLD_RST      = 32'd700;
    localparam logic [23:0] TARGET_GROUP_RST = 24'd4000;
    localparam logic [7:0]  CALL_FLAG_RST    = 8'd0;

    typedef struct packed {
        logic [31:0] current_dest_id;
        logic        rx_audio_active;
        logic        carrier_detected;
        logic        ptt_pressed;
        logic        tx_active;
        logic        slot_idle;
        logic        menu_allows_tx;
        logic        mode_digital;
        logic [31:0] now_ms;
        logic [1:0]  operation;
    } item_t;

    typedef struct packed {
        logic [2:0]  notice;
        logic        active;
        logic [31:0] dest_id;
        logic        dest_write;
        logic        button_changed;
        logic        ptt_out;
    } result_t;

    typedef struct packed {
        logic [7:0]  call_flag;
        logic [23:0] target_group;
        logic [31:0] tx_hold_ms;
        logic [31:0] gap_guard_ms;
        logic [31:0] arm_timeout_ms;
    } cfg_t;

    typedef struct packed {
        logic [31:0] saved_dest;
        logic [31:0] key_start;
        logic        gap_timing;
        logic [31:0] clear_since;
        logic [31:0] arm_start;
        logic [1:0]  phase;
    } state_t;

endpackage

FILE: rtl/core/qgk_step.sv
// One-item step of the quiet-gap keyed transmit controller: next state and result.
// Pure combinational logic; uses qgk_pkg types and codes.
module qgk_step import qgk_pkg::*; (
    input  item_t   item,
    input  cfg_t    cfg,
    input  state_t  cur,
    output state_t  nxt,
    output result_t res
);

    logic [31:0] arm_elapsed;
    logic [31:0] clear_elapsed;
    logic [31:0] key_elapsed;
    logic        chan_clear;
    logic        do_cancel;

    assign arm_elapsed   = item.now_ms - cur.arm_start;
    assign clear_elapsed = item.now_ms - cur.clear_since;
    assign key_elapsed   = item.now_ms - cur.key_start;
    assign chan_clear    = item.slot_idle & ~item.tx_active & ~item.ptt_pressed
                         & ~item.carrier_detected & ~item.rx_audio_active;

    always_comb begin
        nxt                = cur;
        res.ptt_out        = item.ptt_pressed;
        res.button_changed = 1'b0;
        res.dest_write     = 1'b0;
        res.dest_id        = '0;
        res.notice         = NT_NONE;
        do_cancel          = 1'b0;

        case (item.operation)
            OP_ARM: begin
                if (!item.mode_digital) begin
                    res.notice = NT_DIGITAL;
                end else if (cur.phase != PH_IDLE) begin
                    do_cancel = 1'b1;
                end else begin
                    nxt.phase      = PH_ARMED;
                    nxt.arm_start  = item.now_ms;
                    nxt.gap_timing = 1'b0;
                    res.notice     = NT_ARMED;
                end
            end
            OP_ABORT: begin
                do_cancel = 1'b1;
            end
            default: begin
                case (cur.phase)
                    PH_ARMED: begin
                        if (!item.mode_digital) begin
                            do_cancel = 1'b1;
                        end else if (arm_elapsed > cfg.arm_timeout_ms) begin
                            nxt.phase      = PH_IDLE;
                            nxt.gap_timing = 1'b0;
                            res.notice     = NT_GAVE_UP;
                        end else if (!item.menu_allows_tx || !chan_clear) begin
                            nxt.gap_timing = 1'b0;
                        end else if (!cur.gap_timing) begin
                            nxt.gap_timing  = 1'b1;
                            nxt.clear_since = item.now_ms;
                        end else if (clear_elapsed >= cfg.gap_guard_ms) begin
                            nxt.saved_dest     = item.current_dest_id;
                            nxt.phase          = PH_KEYING;
                            nxt.key_start      = item.now_ms;
                            nxt.gap_timing     = 1'b0;
                            res.dest_write     = 1'b1;
                            res.dest_id        = {cfg.call_flag, cfg.target_group};
                            res.ptt_out        = 1'b1;
                            res.button_changed = 1'b1;
                        end
                    end
                    PH_KEYING: begin
                        if (key_elapsed < cfg.tx_hold_ms) begin
                            res.ptt_out = 1'b1;
                        end else begin
                            res.ptt_out        = 1'b0;
                            res.button_changed = 1'b1;
                            nxt.phase          = PH_RELEASING;
                        end
                    end
                    PH_RELEASING: begin
                        res.ptt_out = 1'b0;
                        if (!item.tx_active) begin
                            nxt.phase      = PH_IDLE;
                            nxt.gap_timing = 1'b0;
                            res.dest_write = 1'b1;
                            res.dest_id    = cur.saved_dest;
                            res.notice     = NT_SENT;
                        end
                    end
                    default: begin
                    end
                endcase
            end
        endcase

        // cancel path: back to idle, restore destination if it was replaced
        if (do_cancel && cur.phase != PH_IDLE) begin
            if (cur.phase == PH_KEYING || cur.phase == PH_RELEASING) begin
                res.dest_write = 1'b1;
                res.dest_id    = cur.saved_dest;
            end
            nxt.phase      = PH_IDLE;
            nxt.gap_timing = 1'b0;
            res.notice     = NT_CANCELLED;
        end

        res.active = (nxt.phase != PH_IDLE);
    end

endmodule

FILE: rtl/core/quiet_gap_keyed_transmit_controller_top.sv
// Top level of the quiet-gap keyed transmit controller: stream ports, APB registers,
// input register, state registers and result register. Uses qgk_pkg and qgk_step.
//
//  channel | dir | handshake          | payload
//  --------+-----+--------------------+--------------------------------------------
//  s_      | in  | s_tvalid/s_tready  | s_tuser operation, s_tdata status and times
//  m_      | out | m_tvalid/m_tready  | m_tdata ptt, events, destination, notice
//  apb     | in  | psel/penable/pready| five config registers at 4*i
//
// One item per cycle sustained while m_ accepts results; each item is held in the input register
// and appears on m_ the cycle after its step is evaluated.
// The controller state advances when an item moves from the input register into
// the result register, so consecutive items see each other's effects in order.
// aresetn is synchronous, active low; it clears valids and state and loads the
// config registers with their defaults.
// A stall on m_ holds the result; the input register still takes one more item.
module quiet_gap_keyed_transmit_controller_top import qgk_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    // input item channel
    input  logic        s_tvalid,
    output logic        s_tready,
    // [31:0] now_ms, [32] mode_digital, [33] menu_allows_tx, [34] slot_idle,
    // [35] tx_active, [36] ptt_pressed, [37] carrier_detected,
    // [38] rx_audio_active, [70:39] current_dest_id, [71] zero
    input  logic [71:0] s_tdata,
    // [1:0] operation
    input  logic [1:0]  s_tuser,
    // result channel
    output logic        m_tvalid,
    input  logic        m_tready,
    // [0] ptt_out, [1] button_changed, [2] dest_write, [34:3] dest_id,
    // [35] active, [38:36] notice, [39] zero
    output logic [39:0] m_tdata,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // ---------------- configuration registers ----------------
    cfg_t        cfg_reg;
    logic        cfg_wr;
    logic [2:0]  cfg_idx;

    assign pready  = 1'b1;
    assign cfg_wr  = psel & penable & pwrite;
    assign cfg_idx = paddr[4:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.arm_timeout_ms <= ARM_TIMEOUT_RST;
            cfg_reg.gap_guard_ms   <= GAP_GUARD_RST;
            cfg_reg.tx_hold_ms     <= TX_HOLD_RST;
            cfg_reg.target_group   <= TARGET_GROUP_RST;
            cfg_reg.call_flag      <= CALL_FLAG_RST;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_ARM_TIMEOUT:  cfg_reg.arm_timeout_ms <= pwdata;
                REG_GAP_GUARD:    cfg_reg.gap_guard_ms   <= pwdata;
                REG_TX_HOLD:      cfg_reg.tx_hold_ms     <= pwdata;
                REG_TARGET_GROUP: cfg_reg.target_group   <= pwdata[23:0];
                REG_CALL_FLAG:    cfg_reg.call_flag      <= pwdata[7:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            REG_ARM_TIMEOUT:  prdata = cfg_reg.arm_timeout_ms;
            REG_GAP_GUARD:    prdata = cfg_reg.gap_guard_ms;
            REG_TX_HOLD:      prdata = cfg_reg.tx_hold_ms;
            REG_TARGET_GROUP: prdata = {8'd0, cfg_reg.target_group};
            REG_CALL_FLAG:    prdata = {24'd0, cfg_reg.call_flag};
            default:          prdata = '0;
        endcase
    end

    // ---------------- input register ----------------
    item_t   in_item_reg;
    logic    in_valid_reg;
    logic    step_go;
    logic    out_valid_reg;
    result_t out_res_reg;

    // advance an item when the result register is free or being drained
    assign step_go  = in_valid_reg & (~out_valid_reg | m_tready);
    assign s_tready = ~in_valid_reg | step_go;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_item_reg <= {s_tdata[70:0], s_tuser};
        end
    end

    // ---------------- step logic and controller state ----------------
    state_t  state_reg;
    state_t  state_next;
    result_t step_res;

    qgk_step u_step (
        .item (in_item_reg),
        .cfg  (cfg_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .res  (step_res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '0;
        end else if (step_go) begin
            state_reg <= state_next;
        end
    end

    // ---------------- result register ----------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (step_go) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (step_go) begin
            out_res_reg <= step_res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_res_reg};

    // ---------------- assertions ----------------
    // the active flag of a fresh result matches the phase left behind
    a_active_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        step_go |=> (out_res_reg.active == (state_reg.phase != PH_IDLE)))
        else $error("active flag disagrees with controller phase");

    // a completed send always ends idle with a destination restore
    a_sent_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_res_reg.notice == NT_SENT)
        |-> (!out_res_reg.active && out_res_reg.dest_write))
        else $error("sent notice without restore to idle");

    // no destination value leaks out without a write
    a_dest_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && !out_res_reg.dest_write) |-> (out_res_reg.dest_id == 32'd0))
        else $error("dest_id nonzero without dest_write");

    // input side only blocks while an item sits in the input register
    a_ready_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (in_valid_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a full pipeline");

    // state changes only when an item advances
    a_state_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !$past(step_go) && $past(aresetn) |-> $stable(state_reg))
        else $error("controller state moved without an item");

endmodule
